### rtl/smb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smb_pkg: shared types and constants for the semaphore bank
// words, operation and status codes, control/status bundles, sizes
// ---------------------------------------------------------------------------
package smb_pkg;

  localparam int NUM_SEMS    = 128;
  localparam int SEM_AW      = 7;
  localparam int QUEUE_DEPTH = 16;
  localparam int Q_AW        = 4;
  localparam int REQ_W       = 6;
  localparam int FREE_W      = SEM_AW + 1;
  localparam int ENTRY_W     = 1 + 2 * Q_AW;
  localparam int WAIT_DEPTH  = NUM_SEMS * QUEUE_DEPTH;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UP     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOFREE  = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEM_AW-1:0] sem_id;
    logic             init_value;
    logic [REQ_W-1:0] requester;
  } smb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SEM_AW-1:0] new_id;
    logic              woke_valid;
    logic [REQ_W-1:0]  woke_requester;
  } smb_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic wake;
    logic emit;
  } smb_cmd_t;

  typedef struct packed {
    logic need_wake;
  } smb_sts_t;

endpackage : smb_pkg
`default_nettype wire

### rtl/smb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smb_ram: generic single write port ram
// one write and one registered read per cycle
// ---------------------------------------------------------------------------
module smb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : smb_ram
`default_nettype wire

### rtl/smb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smb_ctrl: sequencing state machine
// steps one operation through lookup, update, waiter read and hand-off
// ---------------------------------------------------------------------------
module smb_ctrl
  import smb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  output      logic     out_valid,
  input  wire logic     out_stall,
  input  wire smb_sts_t sts,
  output      smb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAKE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_wake ? S_WAKE : S_EMIT;
      end
      S_WAKE: begin
        cmd.wake  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : smb_ctrl
`default_nettype wire

### rtl/smb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smb_dp: semaphore datapath
// entry table (value, head, tail), waiter rings, allocator and result regs
// ---------------------------------------------------------------------------
module smb_dp
  import smb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire smb_in_t  in_word,
  input  wire smb_cmd_t cmd,
  output      smb_sts_t sts,
  output      smb_out_t out_word
);

  smb_in_t            item_r;
  smb_out_t           res_r, res_nxt;
  smb_out_t           out_r;
  logic [NUM_SEMS-1:0] vld_r, vld_nxt;
  logic [FREE_W-1:0]  nfree_r, nfree_nxt;

  logic [ENTRY_W-1:0] ent_rdata, ent, ent_wdata;
  logic               ent_we;
  logic [SEM_AW-1:0]  ent_waddr;
  logic               cur_val;
  logic [Q_AW-1:0]    cur_head, cur_tail, head_inc, tail_inc;
  logic               id_ok;

  logic               wt_we;
  logic [REQ_W-1:0]   wt_rdata;
  logic [SEM_AW+Q_AW-1:0] wt_waddr, wt_raddr;

  smb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SEMS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (in_word.sem_id),
    .rdata (ent_rdata)
  );

  smb_ram #(.WIDTH(REQ_W), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (item_r.requester),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  // entries never created read as the reset state
  assign ent      = vld_r[item_r.sem_id] ? ent_rdata : '0;
  assign cur_val  = ent[ENTRY_W-1];
  assign cur_head = ent[2*Q_AW-1:Q_AW];
  assign cur_tail = ent[Q_AW-1:0];
  assign head_inc = cur_head + Q_AW'(1);
  assign tail_inc = cur_tail + Q_AW'(1);
  assign id_ok    = ({1'b0, item_r.sem_id} < FREE_W'(NUM_SEMS));

  assign wt_waddr = {item_r.sem_id, cur_tail};
  assign wt_raddr = {item_r.sem_id, cur_head};

  assign sts.need_wake = (item_r.mode == MODE_UP) && id_ok && (cur_head != cur_tail);

  always_comb begin
    res_nxt   = res_r;
    ent_we    = 1'b0;
    ent_waddr = item_r.sem_id;
    ent_wdata = ent;
    wt_we     = 1'b0;
    nfree_nxt = nfree_r;
    vld_nxt   = vld_r;
    if (cmd.exec) begin
      res_nxt = '0;
      unique case (item_r.mode)
        MODE_CREATE: begin
          if (nfree_r >= FREE_W'(NUM_SEMS)) begin
            res_nxt.status = ST_NOFREE;
          end else begin
            ent_we         = 1'b1;
            ent_waddr      = nfree_r[SEM_AW-1:0];
            ent_wdata      = {item_r.init_value, {(2*Q_AW){1'b0}}};
            res_nxt.new_id = nfree_r[SEM_AW-1:0];
            nfree_nxt      = nfree_r + FREE_W'(1);
          end
        end
        MODE_DOWN: begin
          if (id_ok) begin
            priority if (cur_val) begin
              ent_we    = 1'b1;
              ent_wdata = {1'b0, cur_head, cur_tail};
            end else if (tail_inc == cur_head) begin
              res_nxt.status = ST_FULL;
            end else begin
              wt_we          = 1'b1;
              ent_we         = 1'b1;
              ent_wdata      = {cur_val, cur_head, tail_inc};
              res_nxt.status = ST_BLOCKED;
            end
          end
        end
        MODE_UP: begin
          if (id_ok) begin
            ent_we = 1'b1;
            if (cur_head != cur_tail) begin
              ent_wdata          = {cur_val, head_inc, cur_tail};
              res_nxt.woke_valid = 1'b1;
            end else begin
              ent_wdata = {1'b1, cur_head, cur_tail};
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.wake) begin
      res_nxt.woke_requester = wt_rdata;
    end
    if (ent_we) begin
      vld_nxt[ent_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      nfree_r <= '0;
    end else begin
      vld_r   <= vld_nxt;
      nfree_r <= nfree_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
    res_r <= res_nxt;
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign out_word = out_r;

endmodule : smb_dp
`default_nettype wire

### rtl/semaphore_bank_with_wait_queues.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// semaphore_bank_with_wait_queues: binary semaphores with fifo wait rings
//
//   channel  ports                             word
//   input    in_valid / in_stall / in_word     mode, sem_id, init_value, requester
//   result   out_valid / out_stall / out_word  status, new_id, woke_valid, woke_requester
//
// a word is taken only after the previous one has been handed off to the
// output register, which loads once the entry table read and update are
// done (and the extra waiter ring read for an up that wakes a waiter),
// later while a stalled result still holds it. a new word is taken while a
// result still sits in the output register. reset clears the per-entry
// valid bits and the allocator at once; no clearing pass.
// ---------------------------------------------------------------------------
module semaphore_bank_with_wait_queues
  import smb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire smb_in_t  in_word,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      smb_out_t out_word
);

  smb_cmd_t cmd;
  smb_sts_t sts;

  smb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  smb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule : semaphore_bank_with_wait_queues
`default_nettype wire
